// File: hdl/modbus_response_frame_checker_assert.svh
// Assertion macros used by the checker file of the response frame checker.
`ifndef MODBUS_RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define MODBUS_RESPONSE_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRFC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mrfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mrfc assertion failed");

`endif

// File: hdl/mrfc_pkg.sv
// Types and constants of the Modbus response frame checker.
package mrfc_pkg;

    // Verdict codes carried by each result transaction.
    typedef enum logic [2:0] {
        V_OK    = 3'd0,
        V_SHORT = 3'd1,
        V_CRC   = 3'd2,
        V_ADDR  = 3'd3,
        V_EXC   = 3'd4,
        V_FUNC  = 3'd5
    } verdict_t;

    // Configuration register indexes.
    localparam logic CFG_EXPECTED_ADDRESS  = 1'b0;
    localparam logic CFG_EXPECTED_FUNCTION = 1'b1;

    localparam int unsigned LEN_W = 9;

    localparam logic [15:0]      CRC_INIT        = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY        = 16'hA001;
    localparam logic [7:0]       EXCEPTION_FLAG  = 8'h80;
    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 9'd5;

endpackage

// File: hdl/mrfc_crc_byte.sv
// One-byte update of the reflected CRC-16/MODBUS accumulator.
module mrfc_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // Eight reflected shift steps over the byte, bit 0 first.
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrfc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// File: hdl/modbus_response_frame_checker.sv
// Top level of the Modbus RTU response frame checker.
//
//   channel   direction  payload                                      handshake
//   s_        in         rx_byte[7:0], last_byte                      s_valid / s_ready
//   m_        out        verdict[2:0], exception_code[7:0],           m_valid / m_ready
//                        frame_length[8:0]
//   cfg_      in         cfg_index (0 address, 1 function), cfg_wdata  cfg_we
//
// One byte per cycle while no last byte waits on a stalled result: a byte sits in the
// input register, and from there the byte-wide CRC update and the frame checks finish
// into the result register; the verdict of the last byte is valid on the output from there.
// Reset is synchronous and active low; it clears the frame and loads the defaults.
// A stalled result blocks only a following last byte; plain bytes keep flowing.
module modbus_response_frame_checker #(
    parameter int unsigned MAX_FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [7:0]  m_exception_code,
    output logic [8:0]  m_frame_length
);

    localparam int unsigned LW = mrfc_pkg::LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_FRAME_BYTES);

    logic [7:0]          exp_addr_reg;
    logic [6:0]          exp_func_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic [15:0]         crc_reg;
    logic [15:0]         crc_fed;
    logic [15:0]         crc_next;
    logic [LW-1:0]       count_reg;
    logic [LW-1:0]       count_next;
    logic [7:0]          first_reg;
    logic [7:0]          second_reg;
    logic [7:0]          third_reg;
    logic [7:0]          first_next;
    logic [7:0]          second_next;
    logic [7:0]          third_next;
    logic [7:0]          older_reg;
    logic [7:0]          newer_reg;
    logic                m_valid_reg;
    mrfc_pkg::verdict_t  verdict_reg;
    mrfc_pkg::verdict_t  verdict_next;
    logic [7:0]          code_reg;
    logic [7:0]          code_next;
    logic [LW-1:0]       length_reg;
    logic                out_free;
    logic                proc_fire;
    logic                in_fire;
    logic [15:0]         rx_crc;
    logic [7:0]          exc_func;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_addr_reg <= 8'd1;
            exp_func_reg <= 7'd3;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mrfc_pkg::CFG_EXPECTED_ADDRESS:  exp_addr_reg <= cfg_wdata;
                mrfc_pkg::CFG_EXPECTED_FUNCTION: exp_func_reg <= cfg_wdata[6:0];
            endcase
        end
    end

    // Pipeline handshakes: a byte that yields no result never waits on the output.
    assign out_free  = !m_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign in_fire   = s_valid && s_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_byte_reg <= s_rx_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Feed the byte leaving the two-byte delay line into the CRC.
    mrfc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (older_reg),
        .crc_out (crc_fed)
    );

    // Frame state after absorbing the current byte.
    always_comb begin
        crc_next    = (count_reg >= LW'(2)) ? crc_fed : crc_reg;
        first_next  = (count_reg == LW'(0)) ? in_byte_reg : first_reg;
        second_next = (count_reg == LW'(1)) ? in_byte_reg : second_reg;
        third_next  = (count_reg == LW'(2)) ? in_byte_reg : third_reg;
        count_next  = (count_reg < MAX_LEN) ? count_reg + LW'(1) : count_reg;
    end

    assign rx_crc   = {in_byte_reg, newer_reg};
    assign exc_func = {1'b0, exp_func_reg} | mrfc_pkg::EXCEPTION_FLAG;

    // Verdict, checked in priority order.
    always_comb begin
        code_next = 8'd0;
        if (count_next < mrfc_pkg::MIN_FRAME_BYTES) begin
            verdict_next = mrfc_pkg::V_SHORT;
        end else if (rx_crc != crc_next) begin
            verdict_next = mrfc_pkg::V_CRC;
        end else if (first_next != exp_addr_reg) begin
            verdict_next = mrfc_pkg::V_ADDR;
        end else if (second_next == {1'b0, exp_func_reg}) begin
            verdict_next = mrfc_pkg::V_OK;
        end else if (second_next == exc_func) begin
            verdict_next = mrfc_pkg::V_EXC;
            code_next    = third_next;
        end else begin
            verdict_next = mrfc_pkg::V_FUNC;
        end
    end

    // Frame control state; the last byte restarts the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= mrfc_pkg::CRC_INIT;
            count_reg <= '0;
        end else if (proc_fire) begin
            if (in_last_reg) begin
                crc_reg   <= mrfc_pkg::CRC_INIT;
                count_reg <= '0;
            end else begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
            end
        end
    end

    // Held header bytes and the delay line; they are read only once written.
    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            older_reg  <= newer_reg;
            newer_reg  <= in_byte_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= proc_fire && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && in_last_reg) begin
            verdict_reg <= verdict_next;
            code_reg    <= code_next;
            length_reg  <= count_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_verdict        = verdict_reg;
    assign m_exception_code = code_reg;
    assign m_frame_length   = length_reg;

endmodule

// File: hdl/mrfc_checker.sv
// Port-level assertions for the response frame checker, bound to its top level.
`include "modbus_response_frame_checker_assert.svh"

module mrfc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_we,
    input logic       cfg_index,
    input logic [7:0] cfg_wdata,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       s_last_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_verdict,
    input logic [7:0] m_exception_code,
    input logic [8:0] m_frame_length
);

    // A stalled result transaction holds its payload.
    `MRFC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_verdict) && $stable(m_exception_code) && $stable(m_frame_length))

    // Only a too-short verdict may report fewer than five bytes.
    `MRFC_ASSERT_NOW(a_len_checked, aclk, aresetn, m_valid && (m_verdict != mrfc_pkg::V_SHORT), m_frame_length >= mrfc_pkg::MIN_FRAME_BYTES)

    // A too-short frame still holds at least its last byte.
    `MRFC_ASSERT_NOW(a_len_short, aclk, aresetn, m_valid && (m_verdict == mrfc_pkg::V_SHORT), (m_frame_length < mrfc_pkg::MIN_FRAME_BYTES) && (m_frame_length != 9'd0))

    // The exception code is zero unless the verdict is an exception.
    `MRFC_ASSERT_NOW(a_code_zero, aclk, aresetn, m_valid && (m_verdict != mrfc_pkg::V_EXC), m_exception_code == 8'd0)

endmodule

bind modbus_response_frame_checker mrfc_checker u_mrfc_checker (.*);
